### design/ascii_frame_receiver_unit_macros.svh
// Assertion macros used by the ASCII frame receiver RTL.
`ifndef ASCII_FRAME_RECEIVER_UNIT_MACROS_SVH
`define ASCII_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/afr_pkg.sv
// Types, constants and helpers for the ASCII frame receiver.
`default_nettype none
package afr_pkg;

    typedef logic [7:0] t_byte;

    // Frame layout
    localparam logic [13:0] HDR_LEN   = 14'd12;
    localparam logic [13:0] SHORT_LEN = 14'd17;
    localparam logic [2:0]  WIN_LEN   = 3'd5;
    localparam logic [13:0] POS_MAX   = 14'd16383;
    localparam logic [13:0] SUM_MOD   = 14'd10000;

    // Header field boundaries (byte position after the start pair)
    localparam logic [13:0] LEN_END = 14'd4;
    localparam logic [13:0] CMD_END = 14'd6;
    localparam logic [13:0] SEG_END = 14'd9;

    // Bad-digit flag bits
    localparam int FLD_LEN = 0;
    localparam int FLD_CMD = 1;
    localparam int FLD_SEG = 2;
    localparam int FLD_TOT = 3;

    // Configuration register indexes
    localparam logic [1:0] REG_PREFIX = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_END    = 2'd2;

    // Register reset values
    localparam t_byte PREFIX_RST = 8'hFF;
    localparam t_byte START_RST  = 8'hD8;
    localparam t_byte END_RST    = 8'hD9;

    // Result item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LEN_BAD  = 2'd1;
    localparam logic [1:0] ST_SUM_BAD  = 2'd2;
    localparam logic [1:0] ST_SHORT    = 2'd3;

    localparam t_byte CHAR_ZERO = 8'h30;
    localparam t_byte CHAR_NINE = 8'h39;

    typedef struct packed {
        t_byte prefix_byte;
        t_byte start_byte;
        t_byte end_byte;
    } t_cfg;

    typedef struct packed {
        logic        item_kind;
        t_byte       payload_byte;
        logic [1:0]  frame_status;
        logic [6:0]  command_code;
        logic [9:0]  segment_number;
        logic [9:0]  segment_total;
        logic [13:0] declared_length;
        logic [13:0] payload_count;
        logic [13:0] received_sum;
        logic [13:0] computed_sum;
        logic        frame_last;
    } t_result;

    // Frame state seen by the end-of-frame status logic
    typedef struct packed {
        logic [13:0] length_field;
        logic [6:0]  command_field;
        logic [9:0]  segment_field;
        logic [9:0]  total_field;
        logic [3:0]  bad_digit;
        t_byte       win0;
        t_byte       win1;
        t_byte       win2;
        t_byte       win3;
        logic [2:0]  window_fill;
        logic [13:0] byte_position;
        logic [13:0] payload_count;
        logic        sum_neg;
        logic [13:0] sum_res;
    } t_snap;

    function automatic logic is_digit(input t_byte b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    function automatic logic [3:0] digit_val(input t_byte b);
        t_byte d;
        d = b - CHAR_ZERO;
        return d[3:0];
    endfunction

endpackage
`default_nettype wire

### design/afr_status_calc.sv
// End-of-frame status: checksum decode, sum fold and status priority.
`default_nettype none
module afr_status_calc (
    input  afr_pkg::t_snap   i_snap,
    output afr_pkg::t_result o_status
);
    import afr_pkg::*;

    logic        rs_bad;
    logic [13:0] rs;
    logic [13:0] cs;
    logic [13:0] dl;
    logic        short_frame;

    // Checksum digits held in the first four window slots
    always_comb begin
        rs_bad = !is_digit(i_snap.win0) || !is_digit(i_snap.win1) ||
                 !is_digit(i_snap.win2) || !is_digit(i_snap.win3);
        rs = 14'(digit_val(i_snap.win0)) * 14'd1000 +
             14'(digit_val(i_snap.win1)) * 14'd100 +
             14'(digit_val(i_snap.win2)) * 14'd10 +
             14'(digit_val(i_snap.win3));
        if (rs_bad) begin
            rs = '0;
        end
    end

    // abs(sum) mod 10000 from the signed sum's sign and its residue
    assign cs = (i_snap.sum_neg && (i_snap.sum_res != 14'd0)) ?
                SUM_MOD - i_snap.sum_res : i_snap.sum_res;

    assign dl = i_snap.bad_digit[FLD_LEN] ? 14'd0 : i_snap.length_field;

    assign short_frame = (i_snap.byte_position < SHORT_LEN) ||
                         (i_snap.window_fill < WIN_LEN);

    // Assemble the status item
    always_comb begin
        o_status            = '0;
        o_status.item_kind  = KIND_STATUS;
        o_status.frame_last = 1'b1;
        if (short_frame) begin
            o_status.frame_status = ST_SHORT;
        end else begin
            o_status.command_code    = i_snap.bad_digit[FLD_CMD] ? 7'd0 : i_snap.command_field;
            o_status.segment_number  = i_snap.bad_digit[FLD_SEG] ? 10'd0 : i_snap.segment_field;
            o_status.segment_total   = i_snap.bad_digit[FLD_TOT] ? 10'd0 : i_snap.total_field;
            o_status.declared_length = dl;
            o_status.payload_count   = i_snap.payload_count;
            o_status.received_sum    = rs;
            o_status.computed_sum    = cs;
            if (dl != i_snap.payload_count) begin
                o_status.frame_status = ST_LEN_BAD;
            end else if (rs != cs) begin
                o_status.frame_status = ST_SUM_BAD;
            end else begin
                o_status.frame_status = ST_OK;
            end
        end
    end

endmodule
`default_nettype wire

### design/afr_frame_tracker.sv
// Frame state: marker detection, header digits, hold window and sums.
`default_nettype none
`include "ascii_frame_receiver_unit_macros.svh"
module afr_frame_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  afr_pkg::t_byte   i_rx_byte,
    input  afr_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output afr_pkg::t_result o_res
);
    import afr_pkg::*;

    logic               r_in_frame, n_in_frame;
    t_byte              r_win [WIN_LEN];
    t_byte              n_win [WIN_LEN];
    logic [2:0]         r_fill, n_fill;
    logic [13:0]        r_pos, n_pos;
    logic [13:0]        r_len, n_len;
    logic [6:0]         r_cmd, n_cmd;
    logic [9:0]         r_seg, n_seg;
    logic [9:0]         r_tot, n_tot;
    logic [3:0]         r_bad, n_bad;
    logic signed [22:0] r_sum, n_sum;
    logic [13:0]        r_sum_res, n_sum_res;
    logic [13:0]        r_pay_cnt, n_pay_cnt;
    t_byte              r_prev, n_prev;
    logic               r_prev_valid, n_prev_valid;

    logic               after_prefix;
    logic               is_start;
    logic               is_end;
    logic               dig_ok;
    logic [3:0]         dig;
    t_byte              leaving;
    logic signed [14:0] res_sum;
    t_snap              snap;
    t_result            status_item;

    // Status logic sees the state as it stands before the end byte
    assign snap = '{length_field:  r_len,
                    command_field: r_cmd,
                    segment_field: r_seg,
                    total_field:   r_tot,
                    bad_digit:     r_bad,
                    win0:          r_win[0],
                    win1:          r_win[1],
                    win2:          r_win[2],
                    win3:          r_win[3],
                    window_fill:   r_fill,
                    byte_position: r_pos,
                    payload_count: r_pay_cnt,
                    sum_neg:       r_sum[22],
                    sum_res:       r_sum_res};

    afr_status_calc u_status (
        .i_snap   (snap),
        .o_status (status_item)
    );

    // Marker detection
    assign after_prefix = r_prev_valid && (r_prev == i_cfg.prefix_byte);
    assign is_start     = after_prefix && (i_rx_byte == i_cfg.start_byte);
    assign is_end       = after_prefix && !is_start && r_in_frame &&
                          (i_rx_byte == i_cfg.end_byte);

    assign dig_ok  = is_digit(i_rx_byte);
    assign dig     = digit_val(i_rx_byte);
    assign leaving = r_win[0];
    assign res_sum = $signed({1'b0, r_sum_res}) + $signed({{7{leaving[7]}}, leaving});

    // Next state and result for one byte
    always_comb begin
        n_in_frame   = r_in_frame;
        n_win        = r_win;
        n_fill       = r_fill;
        n_pos        = r_pos;
        n_len        = r_len;
        n_cmd        = r_cmd;
        n_seg        = r_seg;
        n_tot        = r_tot;
        n_bad        = r_bad;
        n_sum        = r_sum;
        n_sum_res    = r_sum_res;
        n_pay_cnt    = r_pay_cnt;
        n_prev       = i_rx_byte;
        n_prev_valid = 1'b1;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (is_start || is_end) begin
            n_in_frame   = is_start;
            n_fill       = '0;
            n_pos        = '0;
            n_len        = '0;
            n_cmd        = '0;
            n_seg        = '0;
            n_tot        = '0;
            n_bad        = '0;
            n_sum        = '0;
            n_sum_res    = '0;
            n_pay_cnt    = '0;
            n_prev       = r_prev;
            n_prev_valid = 1'b0;
            if (is_end) begin
                o_res_valid = 1'b1;
                o_res       = status_item;
            end
        end else if (r_in_frame) begin
            if (r_pos < HDR_LEN) begin
                // header digits
                if (r_pos < LEN_END) begin
                    if (dig_ok) n_len = 14'(r_len * 14'd10) + 14'(dig);
                    else        n_bad[FLD_LEN] = 1'b1;
                end else if (r_pos < CMD_END) begin
                    if (dig_ok) n_cmd = 7'(r_cmd * 7'd10) + 7'(dig);
                    else        n_bad[FLD_CMD] = 1'b1;
                end else if (r_pos < SEG_END) begin
                    if (dig_ok) n_seg = 10'(r_seg * 10'd10) + 10'(dig);
                    else        n_bad[FLD_SEG] = 1'b1;
                end else begin
                    if (dig_ok) n_tot = 10'(r_tot * 10'd10) + 10'(dig);
                    else        n_bad[FLD_TOT] = 1'b1;
                end
            end else if (r_fill < WIN_LEN) begin
                // window still filling
                for (int k = 0; k < WIN_LEN; k++) begin
                    if (r_fill == 3'(k)) n_win[k] = i_rx_byte;
                end
                n_fill = r_fill + 3'd1;
            end else begin
                // oldest held byte leaves as payload
                for (int k = 0; k < WIN_LEN - 1; k++) begin
                    n_win[k] = r_win[k + 1];
                end
                n_win[WIN_LEN - 1] = i_rx_byte;
                if (r_pay_cnt < POS_MAX) begin
                    n_sum     = r_sum + $signed({{15{leaving[7]}}, leaving});
                    n_pay_cnt = r_pay_cnt + 14'd1;
                    if (res_sum < 0) begin
                        n_sum_res = 14'(res_sum + $signed({1'b0, SUM_MOD}));
                    end else if (res_sum >= $signed({1'b0, SUM_MOD})) begin
                        n_sum_res = 14'(res_sum - $signed({1'b0, SUM_MOD}));
                    end else begin
                        n_sum_res = res_sum[13:0];
                    end
                end
                o_res_valid        = 1'b1;
                o_res.item_kind    = KIND_PAYLOAD;
                o_res.payload_byte = leaving;
            end
            if (r_pos < POS_MAX) begin
                n_pos = r_pos + 14'd1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_fill       <= '0;
            r_pos        <= '0;
            r_len        <= '0;
            r_cmd        <= '0;
            r_seg        <= '0;
            r_tot        <= '0;
            r_bad        <= '0;
            r_sum        <= '0;
            r_sum_res    <= '0;
            r_pay_cnt    <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
        end else if (i_accept) begin
            r_in_frame   <= n_in_frame;
            r_fill       <= n_fill;
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_cmd        <= n_cmd;
            r_seg        <= n_seg;
            r_tot        <= n_tot;
            r_bad        <= n_bad;
            r_sum        <= n_sum;
            r_sum_res    <= n_sum_res;
            r_pay_cnt    <= n_pay_cnt;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
        end
    end

    // Hold window payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

    `AFR_ASSERT_IMPL(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= WIN_LEN, "window fill overrun")
    `AFR_ASSERT_IMPL(a_res_range, i_clk, i_rst_n, 1'b1, r_sum_res < SUM_MOD, "sum residue out of range")
    `AFR_ASSERT_IMPL(a_cnt_pos, i_clk, i_rst_n, 1'b1, r_pay_cnt <= r_pos, "payload count past position")
    `AFR_ASSERT_NEXT(a_start_clear, i_clk, i_rst_n, i_accept && is_start, r_in_frame && (r_fill == 3'd0) && (r_pos == 14'd0), "start pair did not restart frame")
    `AFR_ASSERT_IMPL(a_pay_in_frame, i_clk, i_rst_n, i_accept && o_res_valid && (o_res.item_kind == KIND_PAYLOAD), r_in_frame && (r_fill == WIN_LEN), "payload outside a full window")

endmodule
`default_nettype wire

### design/ascii_frame_receiver_unit.sv
// Output: a result is held in the output register from the cycle after its byte is accepted.
// Throughput: one byte per cycle; a byte is taken whenever the output register is
// empty or being drained in the same cycle, so the single output stage sets the rate.
// Reset: synchronous, active low; clears frame state and output valid, and loads the
// marker registers with 0xFF, 0xD8, 0xD9. No clearing pass.
`default_nettype none
module ascii_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_item_kind,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_frame_status,
    output logic [6:0]  o_command_code,
    output logic [9:0]  o_segment_number,
    output logic [9:0]  o_segment_total,
    output logic [13:0] o_declared_length,
    output logic [13:0] o_payload_count,
    output logic [13:0] o_received_sum,
    output logic [13:0] o_computed_sum,
    output logic        o_frame_last
);
    import afr_pkg::*;

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;
    logic    in_accept;
    logic    res_valid;
    t_result res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prefix_byte <= PREFIX_RST;
            r_cfg.start_byte  <= START_RST;
            r_cfg.end_byte    <= END_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PREFIX: r_cfg.prefix_byte <= i_cfg_data;
                REG_START:  r_cfg.start_byte  <= i_cfg_data;
                REG_END:    r_cfg.end_byte    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input transaction
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    afr_frame_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_item_kind       = r_out.item_kind;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_frame_status    = r_out.frame_status;
    assign o_command_code    = r_out.command_code;
    assign o_segment_number  = r_out.segment_number;
    assign o_segment_total   = r_out.segment_total;
    assign o_declared_length = r_out.declared_length;
    assign o_payload_count   = r_out.payload_count;
    assign o_received_sum    = r_out.received_sum;
    assign o_computed_sum    = r_out.computed_sum;
    assign o_frame_last      = r_out.frame_last;

endmodule
`default_nettype wire

### dv/tb_ascii_frame_receiver_unit.sv
// Self-checking testbench for the ASCII frame receiver unit.
module tb_ascii_frame_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import afr_pkg::*;

    typedef t_byte t_byte_q[$];

    // Ways a generated frame departs from a clean one
    typedef enum {
        FLAW_NONE,
        FLAW_LEN,
        FLAW_SUM,
        FLAW_HDR_CHAR,
        FLAW_SUM_CHAR,
        FLAW_SHORT,
        FLAW_RESTART
    } t_frame_flaw;

    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int FINAL_CYCLES  = 12;
    localparam int MAX_REPORTS   = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_PREFIX;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_item_kind;
    logic [7:0]  o_payload_byte;
    logic [1:0]  o_frame_status;
    logic [6:0]  o_command_code;
    logic [9:0]  o_segment_number;
    logic [9:0]  o_segment_total;
    logic [13:0] o_declared_length;
    logic [13:0] o_payload_count;
    logic [13:0] o_received_sum;
    logic [13:0] o_computed_sum;
    logic        o_frame_last;

    ascii_frame_receiver_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_item_kind       (o_item_kind),
        .o_payload_byte    (o_payload_byte),
        .o_frame_status    (o_frame_status),
        .o_command_code    (o_command_code),
        .o_segment_number  (o_segment_number),
        .o_segment_total   (o_segment_total),
        .o_declared_length (o_declared_length),
        .o_payload_count   (o_payload_count),
        .o_received_sum    (o_received_sum),
        .o_computed_sum    (o_computed_sum),
        .o_frame_last      (o_frame_last)
    );

    // Stimulus and scoreboard storage
    t_byte_q rx_backlog;
    t_byte_q payload_buf;
    t_byte_q frame_body;
    t_result awaited_items[$];
    t_result mon_got;
    t_result mon_want;
    int      queued_bytes = 0;
    int      err_count = 0;
    int      src_gap = 0;
    int      sink_gap = 0;
    int      stall_cycles = 0;
    bit      idle_on = 1'b1;

    // Marker registers as the block should hold them
    t_byte   cfg_prefix = PREFIX_RST;
    t_byte   cfg_start = START_RST;
    t_byte   cfg_end = END_RST;

    // Frame tracking state of the predictor
    bit      m_in_frame = 1'b0;
    t_byte   m_win[5];
    int      m_fill;
    int      m_pos;
    int      m_len;
    int      m_cmd;
    int      m_seg;
    int      m_tot;
    logic [3:0] m_bad;
    int      m_sum;
    int      m_paid;
    t_byte   m_last = 8'h00;
    bit      m_last_ok = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic reset_frame_track();
        foreach (m_win[i]) m_win[i] = 8'h00;
        m_fill = 0;
        m_pos  = 0;
        m_len  = 0;
        m_cmd  = 0;
        m_seg  = 0;
        m_tot  = 0;
        m_bad  = 4'b0000;
        m_sum  = 0;
        m_paid = 0;
    endtask

    // Print every field of one result transaction
    function automatic void show_item(input string tag, input t_result r);
        $display("%s kind=%0d byte=%02h st=%0d cmd=%0d seg=%0d tot=%0d",
                 tag, r.item_kind, r.payload_byte, r.frame_status, r.command_code,
                 r.segment_number, r.segment_total);
        $display("%s dl=%0d pc=%0d rs=%0d cs=%0d last=%0d",
                 tag, r.declared_length, r.payload_count, r.received_sum,
                 r.computed_sum, r.frame_last);
    endfunction

    // Predict the result (if any) of one accepted receive byte
    task automatic decode_rx_byte(input t_byte b);
        logic    marker_ok;
        t_byte   leaving;
        t_result item;
        int      fld;
        int      dval;
        int      dl;
        int      cmd;
        int      sn;
        int      st;
        int      rs;
        int      cs;
        bit      rs_bad;
        marker_ok = m_last_ok && (m_last == cfg_prefix);
        if (marker_ok && b == cfg_start) begin
            // start pair wins even when start and end bytes match
            reset_frame_track();
            m_in_frame = 1'b1;
            m_last_ok  = 1'b0;
        end else if (marker_ok && b == cfg_end && m_in_frame) begin
            item = '0;
            item.item_kind  = KIND_STATUS;
            item.frame_last = 1'b1;
            if (m_pos < SHORT_LEN || m_fill < WIN_LEN) begin
                item.frame_status = ST_SHORT;
            end else begin
                dl  = m_bad[FLD_LEN] ? 0 : m_len;
                cmd = m_bad[FLD_CMD] ? 0 : m_cmd;
                sn  = m_bad[FLD_SEG] ? 0 : m_seg;
                st  = m_bad[FLD_TOT] ? 0 : m_tot;
                rs = 0;
                rs_bad = 1'b0;
                for (int i = 0; i < 4; i++) begin
                    if (m_win[i] >= CHAR_ZERO && m_win[i] <= CHAR_NINE) begin
                        rs = rs * 10 + int'(m_win[i] - CHAR_ZERO);
                    end else begin
                        rs_bad = 1'b1;
                    end
                end
                if (rs_bad) rs = 0;
                cs = (m_sum < 0 ? -m_sum : m_sum) % 10000;
                item.command_code    = cmd[6:0];
                item.segment_number  = sn[9:0];
                item.segment_total   = st[9:0];
                item.declared_length = dl[13:0];
                item.payload_count   = m_paid[13:0];
                item.received_sum    = rs[13:0];
                item.computed_sum    = cs[13:0];
                if (dl != m_paid) begin
                    item.frame_status = ST_LEN_BAD;
                end else if (rs != cs) begin
                    item.frame_status = ST_SUM_BAD;
                end else begin
                    item.frame_status = ST_OK;
                end
            end
            awaited_items.push_back(item);
            m_in_frame = 1'b0;
            reset_frame_track();
            m_last_ok = 1'b0;
        end else begin
            if (m_in_frame) begin
                if (m_pos < HDR_LEN) begin
                    // header digits; a non-digit poisons its whole field
                    fld = (m_pos < LEN_END) ? FLD_LEN :
                          (m_pos < CMD_END) ? FLD_CMD :
                          (m_pos < SEG_END) ? FLD_SEG : FLD_TOT;
                    dval = int'(b) - int'(CHAR_ZERO);
                    if (b < CHAR_ZERO || b > CHAR_NINE) begin
                        m_bad[fld] = 1'b1;
                    end else begin
                        case (fld)
                            FLD_LEN: m_len = m_len * 10 + dval;
                            FLD_CMD: m_cmd = m_cmd * 10 + dval;
                            FLD_SEG: m_seg = m_seg * 10 + dval;
                            default: m_tot = m_tot * 10 + dval;
                        endcase
                    end
                end else if (m_fill < WIN_LEN) begin
                    m_win[m_fill] = b;
                    m_fill++;
                end else begin
                    // oldest held byte leaves as payload
                    leaving = m_win[0];
                    for (int i = 0; i < 4; i++) m_win[i] = m_win[i + 1];
                    m_win[4] = b;
                    if (m_paid < POS_MAX) begin
                        m_sum += int'($signed(leaving));
                        m_paid++;
                    end
                    item = '0;
                    item.item_kind    = KIND_PAYLOAD;
                    item.payload_byte = leaving;
                    awaited_items.push_back(item);
                end
                if (m_pos < POS_MAX) m_pos++;
            end
            m_last    = b;
            m_last_ok = 1'b1;
        end
    endtask

    function automatic void queue_rx(input t_byte b);
        rx_backlog.push_back(b);
        queued_bytes++;
    endfunction

    // A byte that is neither a digit nor any marker byte
    function automatic t_byte non_digit();
        t_byte b;
        do begin
            b = t_byte'($urandom_range(0, 255));
        end while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == cfg_prefix ||
                   b == cfg_start || b == cfg_end);
        return b;
    endfunction

    task automatic put_digits(input int value, input int width);
        int scale;
        scale = 1;
        repeat (width - 1) scale *= 10;
        repeat (width) begin
            frame_body.push_back(t_byte'(int'(CHAR_ZERO) + (value / scale) % 10));
            scale /= 10;
        end
    endtask

    // Random payload that never forms a marker pair by itself
    task automatic fill_payload(input int n);
        t_byte b;
        t_byte prev;
        payload_buf.delete();
        prev = CHAR_ZERO;
        repeat (n) begin
            do begin
                b = t_byte'($urandom_range(0, 255));
            end while (prev == cfg_prefix && (b == cfg_start || b == cfg_end));
            payload_buf.push_back(b);
            prev = b;
        end
    endtask

    // Build one frame around payload_buf and queue it
    task automatic send_frame(input t_frame_flaw flaw, input bit hdr_max);
        int sum;
        int decl;
        int chk;
        int cut;
        sum = 0;
        foreach (payload_buf[i]) sum += int'($signed(payload_buf[i]));
        decl = payload_buf.size() % 10000;
        chk  = (sum < 0 ? -sum : sum) % 10000;
        if (flaw == FLAW_LEN) decl = (decl + int'($urandom_range(1, 50))) % 10000;
        if (flaw == FLAW_SUM) chk = (chk + int'($urandom_range(1, 50))) % 10000;
        frame_body.delete();
        if (hdr_max) begin
            put_digits(9999, 4);
            put_digits(99, 2);
            put_digits(999, 3);
            put_digits(999, 3);
        end else begin
            put_digits(decl, 4);
            put_digits($urandom_range(0, 99), 2);
            put_digits($urandom_range(0, 999), 3);
            put_digits($urandom_range(0, 999), 3);
        end
        foreach (payload_buf[i]) frame_body.push_back(payload_buf[i]);
        put_digits(chk, 4);
        cut = frame_body.size();
        case (flaw)
            FLAW_HDR_CHAR: frame_body[$urandom_range(0, 11)] = non_digit();
            FLAW_SUM_CHAR: frame_body[cut - 1 - $urandom_range(0, 3)] = non_digit();
            FLAW_SHORT:    cut = $urandom_range(0, 15);
            FLAW_RESTART:  cut = $urandom_range(0, frame_body.size());
            default:       cut = frame_body.size();
        endcase
        queue_rx(cfg_prefix);
        queue_rx(cfg_start);
        for (int i = 0; i < cut; i++) queue_rx(frame_body[i]);
        // an abandoned frame is cut off by whatever start or end pair follows
        if (flaw != FLAW_RESTART) begin
            queue_rx(cfg_prefix);
            queue_rx(cfg_end);
        end
    endtask

    // Mostly clean frames with random content, plus flawed frames and line noise
    task automatic random_traffic(input int budget);
        int stop_at;
        int pick;
        int plen;
        stop_at = queued_bytes + budget;
        while (queued_bytes < stop_at) begin
            pick = $urandom_range(0, 99);
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) :
                                                 $urandom_range(0, 16);
            fill_payload(plen);
            if (pick < 60) begin
                send_frame(FLAW_NONE, 1'b0);
            end else if (pick < 66) begin
                send_frame(FLAW_LEN, 1'b0);
            end else if (pick < 72) begin
                send_frame(FLAW_SUM, 1'b0);
            end else if (pick < 77) begin
                send_frame(FLAW_HDR_CHAR, 1'b0);
            end else if (pick < 82) begin
                send_frame(FLAW_SUM_CHAR, 1'b0);
            end else if (pick < 88) begin
                send_frame(FLAW_SHORT, 1'b0);
            end else if (pick < 94) begin
                send_frame(FLAW_RESTART, 1'b0);
            end else begin
                repeat ($urandom_range(1, 12)) queue_rx(t_byte'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1) begin
                    queue_rx(cfg_prefix);
                    queue_rx(cfg_end);
                end
            end
        end
    endtask

    // Block until every queued byte went in and every result came out
    task automatic wait_idle(input int extra);
        do begin
            @(negedge i_clk);
        end while (rx_backlog.size() != 0 || i_in_valid || awaited_items.size() != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic load_markers(input t_byte p, input t_byte s, input t_byte e);
        cfg_prefix = p;
        cfg_start  = s;
        cfg_end    = e;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_PREFIX;
        i_cfg_data  <= p;
        @(posedge i_clk);
        i_cfg_index <= REG_START;
        i_cfg_data  <= s;
        @(posedge i_clk);
        i_cfg_index <= REG_END;
        i_cfg_data  <= e;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Byte driver: predicts on each accepted transaction, refills from the backlog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_rx_byte(i_rx_byte);
            end
            if (!i_in_valid || o_in_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_in_valid <= 1'b0;
                end else if (idle_on && rx_backlog.size() != 0 &&
                             $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 6);
                    i_in_valid <= 1'b0;
                end else if (rx_backlog.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= rx_backlog.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                mon_got = {o_item_kind, o_payload_byte, o_frame_status, o_command_code,
                           o_segment_number, o_segment_total, o_declared_length,
                           o_payload_count, o_received_sum, o_computed_sum, o_frame_last};
                if (awaited_items.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        show_item("unexpected result:", mon_got);
                    end
                end else begin
                    mon_want = awaited_items.pop_front();
                    if (mon_got !== mon_want) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            show_item("mismatch exp:", mon_want);
                            show_item("mismatch got:", mon_got);
                        end
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 6);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        reset_frame_track();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames on reset marker values
        queue_rx(cfg_prefix);
        queue_rx(cfg_end);                  // end marker with no open frame
        payload_buf.delete();
        send_frame(FLAW_NONE, 1'b0);        // empty payload
        payload_buf = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hFF, 8'h41};
        send_frame(FLAW_NONE, 1'b0);        // byte extremes, prefix inside payload
        payload_buf = '{8'h80, 8'h80, 8'h80};
        send_frame(FLAW_NONE, 1'b0);        // negative running sum
        payload_buf = '{8'h31, 8'hC3};
        send_frame(FLAW_LEN, 1'b1);         // all-nines header
        fill_payload(5);
        send_frame(FLAW_SUM, 1'b0);
        fill_payload(1);
        send_frame(FLAW_HDR_CHAR, 1'b0);
        fill_payload(2);
        send_frame(FLAW_SUM_CHAR, 1'b0);
        queue_rx(cfg_prefix);               // start pair straight into end pair
        queue_rx(cfg_start);
        queue_rx(cfg_prefix);
        queue_rx(cfg_end);
        fill_payload(4);
        send_frame(FLAW_RESTART, 1'b0);
        fill_payload(3);
        send_frame(FLAW_NONE, 1'b0);
        random_traffic(100);
        wait_idle(SETTLE_CYCLES);

        // Zero prefix, all-ones start byte
        load_markers(8'h00, 8'hFF, 8'h80);
        random_traffic(100);
        wait_idle(SETTLE_CYCLES);

        // Start and end bytes equal: every closing pair reopens instead
        idle_on = 1'b0;
        load_markers(8'hFF, 8'h00, 8'h00);
        random_traffic(100);
        wait_idle(SETTLE_CYCLES);

        // Prefix equal to start byte; second marker byte must not pair again
        idle_on = 1'b1;
        load_markers(8'h7E, 8'h7E, 8'h7D);
        queue_rx(8'h7E);
        queue_rx(8'h7E);
        queue_rx(8'h7D);
        random_traffic(100);
        wait_idle(SETTLE_CYCLES);

        // Back to reset markers for a final stretch with no idling
        idle_on = 1'b0;
        load_markers(PREFIX_RST, START_RST, END_RST);
        random_traffic(100);
        wait_idle(FINAL_CYCLES);

        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
